[rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way sorted merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int VALUE_W    = 32;   // element value width
    localparam int LIST_ID_W  = 3;    // list number field width
    localparam int CFG_W      = 4;    // lists_in_use register width
    localparam int IN_USER_W  = 4;    // {list_empty, list_id}
    localparam int OUT_USER_W = 4;    // {needs_refill, source_list}

    localparam int USER_EMPTY_BIT  = 3;
    localparam int USER_REFILL_BIT = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_END,
        ST_POP
    } kwm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // take the input item into the head store
        logic restart;     // return all per-list state to start
        logic scan_clear;  // start a new minimum search
        logic scan_run;    // issue the next head read of the search
        logic pop;         // load the best head into the output register
    } kwm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_ok;       // input item is for a list in use that is awaited
        logic any_wait;      // some list in use still awaits an element
        logic all_done;      // every list in use is finished
        logic scan_last;     // search read address is the last list in use
        logic best_found;    // search saw at least one pending head
        logic best_is_last;  // best head is its list's last element
        logic pop_all_done;  // popping the best head finishes the stream
        logic out_free;      // output register can take a result this cycle
    } kwm_status_t;

endpackage

[rtl/kwm_ram.sv]
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[rtl/kwm_datapath.sv]
// ----------------------------------------------------------------------------
// kwm_datapath
// Per-list head state, head value RAM, serial minimum search and output
// register of the merge core.
// ----------------------------------------------------------------------------
module kwm_datapath #(
    parameter int NUM_LISTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [kwm_pkg::VALUE_W-1:0]     s_axis_tdata,
    input  logic [kwm_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kwm_pkg::VALUE_W-1:0]     m_axis_tdata,
    output logic [kwm_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast,
    input  kwm_pkg::kwm_cmd_t               cmd,
    output kwm_pkg::kwm_status_t            status
);

    import kwm_pkg::*;

    localparam int IDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

    logic [CFG_W-1:0]     cfg_reg;
    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     k_val;
    logic [NUM_LISTS-1:0] inuse;

    logic [NUM_LISTS-1:0] valid_reg,    valid_next;
    logic [NUM_LISTS-1:0] is_last_reg,  is_last_next;
    logic [NUM_LISTS-1:0] done_reg,     done_next;
    logic [NUM_LISTS-1:0] awaiting_reg, awaiting_next;

    logic [CMP_W-1:0]     id_ext;
    logic [IDX_W-1:0]     id_idx;
    logic                 in_empty;

    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_pend_reg;
    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [VALUE_W-1:0]   best_val_reg;
    logic [VALUE_W-1:0]   head_rdata;
    logic                 take_best;
    logic [NUM_LISTS-1:0] best_onehot;
    logic [CMP_W-1:0]     best_ext;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [LIST_ID_W-1:0] out_src_reg;
    logic                 out_refill_reg;
    logic                 out_last_reg;

    // ---- configuration and list-in-use mask ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    assign cfg_ext = CMP_W'(cfg_reg);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            k_val = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(NUM_LISTS))
        begin
            k_val = CMP_W'(NUM_LISTS);
        end
        else
        begin
            k_val = cfg_ext;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            inuse[i] = (CMP_W'(i) < k_val);
        end
    end

    // ---- input item decode ----
    assign id_ext   = CMP_W'(s_axis_tuser[LIST_ID_W-1:0]);
    assign id_idx   = id_ext[IDX_W-1:0];
    assign in_empty = s_axis_tuser[USER_EMPTY_BIT];

    // ---- head value store ----
    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_LISTS)
    ) u_head_ram (
        .clk   (clk),
        .we    (cmd.accept && !in_empty),
        .waddr (id_idx),
        .wdata (s_axis_tdata),
        .raddr (idx_reg),
        .rdata (head_rdata)
    );

    // ---- per-list flags ----
    always_comb
    begin
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            best_onehot[i] = (IDX_W'(i) == best_idx_reg);
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        is_last_next  = is_last_reg;
        done_next     = done_reg;
        awaiting_next = awaiting_reg;
        if (cmd.restart)
        begin
            valid_next    = '0;
            is_last_next  = '0;
            done_next     = '0;
            awaiting_next = '1;
        end
        else if (cmd.accept)
        begin
            awaiting_next[id_idx] = 1'b0;
            if (in_empty)
            begin
                done_next[id_idx] = 1'b1;
            end
            else
            begin
                valid_next[id_idx]   = 1'b1;
                is_last_next[id_idx] = s_axis_tlast;
            end
        end
        else if (cmd.pop)
        begin
            valid_next[best_idx_reg] = 1'b0;
            if (is_last_reg[best_idx_reg])
            begin
                done_next[best_idx_reg] = 1'b1;
            end
            else
            begin
                awaiting_next[best_idx_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            is_last_reg  <= '0;
            done_reg     <= '0;
            awaiting_reg <= '1;
        end
        else
        begin
            valid_reg    <= valid_next;
            is_last_reg  <= is_last_next;
            done_reg     <= done_next;
            awaiting_reg <= awaiting_next;
        end
    end

    // ---- serial minimum search: one read issued, one compare per cycle ----
    assign take_best = rd_pend_reg && valid_reg[rd_idx_reg] &&
                       (!best_found_reg || ($signed(head_rdata) < $signed(best_val_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_run;
            if (cmd.scan_run)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (take_best)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_run)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (take_best)
        begin
            best_idx_reg <= rd_idx_reg;
            best_val_reg <= head_rdata;
        end
    end

    // ---- output register ----
    assign best_ext = CMP_W'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_value_reg  <= best_val_reg;
            out_src_reg    <= best_ext[LIST_ID_W-1:0];
            out_refill_reg <= !is_last_reg[best_idx_reg];
            out_last_reg   <= status.pop_all_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_refill_reg, out_src_reg};
    assign m_axis_tlast  = out_last_reg;

    // ---- status ----
    always_comb
    begin
        status.item_ok      = (id_ext < k_val) && awaiting_reg[id_idx];
        status.any_wait     = |(awaiting_reg & inuse);
        status.all_done     = &(done_reg | ~inuse);
        status.scan_last    = (CMP_W'(idx_reg) == (k_val - CMP_W'(1)));
        status.best_found   = best_found_reg;
        status.best_is_last = is_last_reg[best_idx_reg];
        status.pop_all_done = &(done_reg | ~inuse |
                                (is_last_reg[best_idx_reg] ? best_onehot : '0));
        status.out_free     = !out_valid_reg || m_axis_tready;
    end

    // ---- assertions ----
    a_accept_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> awaiting_reg[id_idx])
        else $error("item taken for a list that was not awaited");

    a_last_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !out_refill_reg)
        else $error("final result asks for a refill");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> out_valid_reg)
        else $error("popped result not presented");

endmodule

[rtl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer of the merge core: item intake, readiness check, head search
// and pop.
// ----------------------------------------------------------------------------
module kwm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  kwm_pkg::kwm_status_t status,
    output kwm_pkg::kwm_cmd_t    cmd
);

    import kwm_pkg::*;

    kwm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                // items for lists not awaited are dropped here
                if (s_axis_tvalid && status.item_ok)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.all_done)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (status.any_wait)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                // last read data is compared this cycle
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (!status.best_found)
                begin
                    cmd.restart = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (status.pop_all_done)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (status.best_is_last)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---- assertions ----
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> status.out_free)
        else $error("pop while output register is occupied");

    a_scan_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_END) |-> ($past(state_reg) == ST_SCAN))
        else $error("search ended without a scan");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_CHECK))
        else $error("accepted item not followed by readiness check");

endmodule

[rtl/k_way_sorted_merge_core.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// Merges up to NUM_LISTS ascending streams of signed 32-bit values into one
// ascending stream.
// ----------------------------------------------------------------------------
// The core holds one pending head per list. An input item delivers the next
// element of one list (or reports the list empty) and is taken only for a
// list that is in use and awaited; any other item is consumed and dropped.
// Once no list in use is awaited, the core searches the pending heads
// serially through the read port of the head RAM, one list per cycle, and
// emits the smallest (ties go to the lower list number). A result that asks
// for a refill means the core now waits for that list; popping a list's last
// element lets the next search start without new input. After the final element (tlast)
// all per-list state returns to start. An item is taken from the idle state, and
// each pop runs through the readiness check, k head reads (k being the number of
// lists in use), the last compare and the pop; with a free output the search sets the pace.
// Results wait in an output register; the input side is not blocked by a
// stalled output until the next pop needs that register. lists_in_use is
// written through cfg_we/cfg_wdata by the user only while the core is idle;
// the core itself does not enforce this. 0 acts as 1 and values above
// NUM_LISTS act as NUM_LISTS.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core #(
    parameter int NUM_LISTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: lists_in_use
    input  logic                            cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]       cfg_wdata,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kwm_pkg::VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic [kwm_pkg::IN_USER_W-1:0]   s_axis_tuser,   // [2:0] list_id, [3] list_empty
    input  logic                            s_axis_tlast,   // last_of_list
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kwm_pkg::VALUE_W-1:0]     m_axis_tdata,   // [31:0] value_res
    output logic [kwm_pkg::OUT_USER_W-1:0]  m_axis_tuser,   // [2:0] source_list, [3] needs_refill
    output logic                            m_axis_tlast    // last of merged stream
);

    import kwm_pkg::*;

    kwm_cmd_t    cmd;
    kwm_status_t status;

    // sequencer
    kwm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // head store, search and output register
    kwm_datapath #(
        .NUM_LISTS (NUM_LISTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_way_sorted_merge_core.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers the list-count extremes, ties,
// value extremes, empty lists and ignored items. Random merge streams follow,
// with random list lengths and contents and some stray items mixed in. Every
// accepted item runs through a local merge predictor, and each result item is
// compared with the oldest expected entry. Both sides of the stream idle at
// random in the first two of three phases; the last phase has no idling.
// ----------------------------------------------------------------------------
module tb;

    import kwm_pkg::*;

    localparam int MAX_LISTS    = 8;
    localparam int RANDOM_ITEMS = 110;
    localparam int SETTLE_CYC   = 40;       // longer than one pop plus intake
    localparam int END_CYC      = 60;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    // how a directed row is checked
    localparam logic [1:0] CHK_MODEL = 2'd0;   // predictor decides
    localparam logic [1:0] CHK_NONE  = 2'd1;   // no result may come
    localparam logic [1:0] CHK_ONE   = 2'd2;   // exactly the typed result

    typedef struct packed {
        logic [LIST_ID_W-1:0]      list_id;
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_list;
        logic                      list_empty;
    } merge_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [LIST_ID_W-1:0]      src;
        logic                      refill;
        logic                      last;
    } merge_res_t;

    typedef struct packed {
        logic             cfg_on;
        logic [CFG_W-1:0] cfg_val;
        merge_item_t      item;
        logic [1:0]       chk;
        merge_res_t       want;
    } dir_row_t;

    localparam merge_res_t NO_RES = '0;

    // Directed rows. A config write, when present, lands before the row's item.
    dir_row_t dir_rows [21] = '{
        // one list: an out-of-range list is dropped, a lone last element ends it
        '{1'b1, 4'd1, '{3'd3, 32'h1234_5678, 1'b0, 1'b0}, CHK_NONE, NO_RES},
        '{1'b0, 4'd0, '{3'd0, 32'h0000_0005, 1'b1, 1'b0}, CHK_ONE,
          '{32'h0000_0005, 3'd0, 1'b0, 1'b1}},
        // zero acts as one: empty stream, then the value extremes
        '{1'b1, 4'd0, '{3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}, CHK_NONE, NO_RES},
        '{1'b0, 4'd0, '{3'd0, 32'h8000_0000, 1'b0, 1'b0}, CHK_ONE,
          '{32'h8000_0000, 3'd0, 1'b1, 1'b0}},
        '{1'b0, 4'd0, '{3'd0, 32'h7FFF_FFFF, 1'b1, 1'b0}, CHK_ONE,
          '{32'h7FFF_FFFF, 3'd0, 1'b0, 1'b1}},
        // 15 clamps to eight lists: repeat item dropped, ties, burst of pops
        '{1'b1, 4'd15, '{3'd1, 32'hFFFF_FFFB, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd1, 32'h0000_0063, 1'b0, 1'b0}, CHK_NONE, NO_RES},
        '{1'b0, 4'd0, '{3'd0, 32'h0000_0064, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd2, 32'hDEAD_BEEF, 1'b1, 1'b1}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd3, 32'h0000_0064, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd4, 32'h8000_0000, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd5, 32'h7FFF_FFFF, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd6, 32'h0000_0000, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd7, 32'h0000_0064, 1'b0, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd7, 32'h7FFF_FFFF, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        // three lists: refills, chained pops, stream ending on an empty report
        '{1'b1, 4'd3, '{3'd2, 32'h0000_0007, 1'b0, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd0, 32'h0000_0001, 1'b0, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd1, 32'h0000_0002, 1'b1, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd0, 32'h0000_0003, 1'b0, 1'b0}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd0, 32'h0000_0000, 1'b0, 1'b1}, CHK_MODEL, NO_RES},
        '{1'b0, 4'd0, '{3'd2, 32'h5555_AAAA, 1'b1, 1'b1}, CHK_MODEL, NO_RES}
    };

    // ------------------------------------------------------------------------
    // DUT hookup; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [VALUE_W-1:0]     s_axis_tdata  = '0;     // [31:0] value
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;     // [2:0] list_id, [3] list_empty
    logic                   s_axis_tlast  = 1'b0;   // last_of_list
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]     m_axis_tdata;           // [31:0] value_res
    logic [OUT_USER_W-1:0]  m_axis_tuser;           // [2:0] source_list, [3] needs_refill
    logic                   m_axis_tlast;

    k_way_sorted_merge_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Merge predictor: its own copy of the register and the per-list heads
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]          lists_cfg;
    logic signed [VALUE_W-1:0] head_val  [MAX_LISTS];
    bit                        head_ok   [MAX_LISTS];
    bit                        head_last [MAX_LISTS];
    bit                        list_fin  [MAX_LISTS];
    bit                        list_wait [MAX_LISTS];
    bit                        stream_closed;      // set when the merge returns to start
    merge_res_t                step_res[$];        // results of the latest item
    merge_res_t                merge_expect_q[$];  // results still owed by the DUT

    // bookkeeping
    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    int  cycles         = 0;
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  items_sent     = 0;
    int  items_taken    = 0;
    int  random_taken   = 0;
    int  streams        = 0;
    int  cfg_writes     = 0;
    int  most_per_step  = 0;
    bit  held_once      = 1'b0;

    function automatic int eff_lists(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_LISTS)
            return MAX_LISTS;
        return int'(v);
    endfunction

    function automatic void merge_restart();
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            head_val[i]  = '0;
            head_ok[i]   = 1'b0;
            head_last[i] = 1'b0;
            list_fin[i]  = 1'b0;
            list_wait[i] = 1'b1;
        end
        stream_closed = 1'b1;
    endfunction

    // Applies one accepted item. Returns 1 if the merge took it; the pops it
    // triggers are left in step_res.
    function automatic bit merge_step(merge_item_t it);
        int                        k;
        int                        best;
        bit                        busy;
        bit                        any_wait;
        bit                        all_fin;
        bit                        was_last;
        logic signed [VALUE_W-1:0] best_val;
        merge_res_t                r;

        k = eff_lists(lists_cfg);
        step_res.delete();
        if (int'(it.list_id) >= k || !list_wait[it.list_id])
            return 1'b0;

        list_wait[it.list_id] = 1'b0;
        if (it.list_empty)
            list_fin[it.list_id] = 1'b1;
        else
        begin
            head_val[it.list_id]  = it.value;
            head_ok[it.list_id]   = 1'b1;
            head_last[it.list_id] = it.last_of_list;
        end

        busy = 1'b1;
        while (busy)
        begin
            any_wait = 1'b0;
            all_fin  = 1'b1;
            for (int i = 0; i < k; i++)
            begin
                if (list_wait[i])
                    any_wait = 1'b1;
                if (!list_fin[i])
                    all_fin = 1'b0;
            end
            if (all_fin)
            begin
                merge_restart();
                busy = 1'b0;
            end
            else if (any_wait)
                busy = 1'b0;
            else
            begin
                // strict less-than keeps the lower list on a tie
                best     = -1;
                best_val = '0;
                for (int i = 0; i < k; i++)
                    if (head_ok[i] && (best < 0 || head_val[i] < best_val))
                    begin
                        best     = i;
                        best_val = head_val[i];
                    end
                if (best < 0)
                begin
                    // nothing pending and nothing awaited: treat as finished
                    merge_restart();
                    busy = 1'b0;
                end
                else
                begin
                    was_last      = head_last[best];
                    head_ok[best] = 1'b0;
                    r.value       = best_val;
                    r.src         = best[LIST_ID_W-1:0];
                    r.last        = 1'b0;
                    if (was_last)
                    begin
                        list_fin[best] = 1'b1;
                        r.refill       = 1'b0;
                    end
                    else
                    begin
                        list_wait[best] = 1'b1;
                        r.refill        = 1'b1;
                    end
                    all_fin = 1'b1;
                    for (int i = 0; i < k; i++)
                        if (!list_fin[i])
                            all_fin = 1'b0;
                    if (all_fin)
                    begin
                        r.last = 1'b1;
                        merge_restart();
                        busy = 1'b0;
                    end
                    else if (!was_last)
                        busy = 1'b0;
                    step_res.push_back(r);
                end
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the in-order checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        merge_res_t got;
        merge_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value  = m_axis_tdata;
            got.src    = m_axis_tuser[LIST_ID_W-1:0];
            got.refill = m_axis_tuser[USER_REFILL_BIT];
            got.last   = m_axis_tlast;
            results_seen++;
            if (merge_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d: unexpected result value=%0d list=%0d refill=%0b last=%0b",
                             cycles, got.value, got.src, got.refill, got.last);
            end
            else
            begin
                want = merge_expect_q.pop_front();
                if (got.value !== want.value || got.src !== want.src ||
                    got.refill !== want.refill || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("cycle %0d: expected value=%0d list=%0d refill=%0b last=%0b, %s",
                                 cycles, want.value, want.src, want.refill, want.last,
                                 $sformatf("got value=%0d list=%0d refill=%0b last=%0b",
                                           got.value, got.src, got.refill, got.last));
                end
            end
        end
    end

    // hard stop if the DUT hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, merge_expect_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Presents one item, holds it until the DUT takes it, then runs the
    // predictor. tvalid is only dropped inside an idle gap or a drain, so a
    // back-to-back item never sees a low and a high assignment in the same step.
    task automatic send_item(input merge_item_t it, input bit use_model, output bit taken);
        logic [IN_USER_W-1:0] user;
        user                  = '0;
        user[LIST_ID_W-1:0]   = it.list_id;
        user[USER_EMPTY_BIT]  = it.list_empty;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.value;
        s_axis_tuser  <= user;
        s_axis_tlast  <= it.last_of_list;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        taken = merge_step(it);
        if (taken)
            items_taken++;
        if (step_res.size() > most_per_step)
            most_per_step = step_res.size();
        if (use_model)
            foreach (step_res[i])
                merge_expect_q.push_back(step_res[i]);
    endtask

    // sender holds off until every owed result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (merge_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // lists_in_use may only change while the core is idle; an item that made
    // no result can still be in flight, so give it a pop's worth of cycles
    task automatic write_lists(input logic [CFG_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lists_cfg = v;
        cfg_writes++;
    endtask

    // One whole merge: picks a list count, builds a sorted run per list, then
    // feeds whichever list the merge is waiting on, with stray items mixed in.
    task automatic run_stream();
        merge_item_t               list_feed [MAX_LISTS][$];
        merge_item_t               it;
        logic signed [VALUE_W-1:0] vals [5];
        logic signed [VALUE_W-1:0] tmp;
        int                        cand [MAX_LISTS];
        int                        k;
        int                        n;
        int                        nc;
        int                        fed;
        bit                        end_by_flag;
        bit                        taken;

        // idling phases: sender-light, then receiver-light, then none
        if (random_taken < RANDOM_ITEMS / 3)
        begin
            send_gap_pct   = 27;
            recv_stall_pct = 53;
        end
        else if (random_taken < 2 * RANDOM_ITEMS / 3)
        begin
            send_gap_pct   = 53;
            recv_stall_pct = 27;
        end
        else
        begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end

        if ($urandom_range(3) != 0)
            write_lists(CFG_W'($urandom_range(MAX_LISTS, 1)));
        else
            write_lists(CFG_W'($urandom_range(15)));
        k = eff_lists(lists_cfg);
        streams++;

        for (int l = 0; l < MAX_LISTS; l++)
        begin
            list_feed[l].delete();
            if (l >= k)
                continue;
            n = $urandom_range(4);
            for (int j = 0; j < n; j++)
                case ($urandom_range(4))
                    0: vals[j] = $signed($urandom_range(8)) - 4;            // tie bait
                    1: vals[j] = {1'b1, 31'($urandom_range(3))};            // near min
                    2: vals[j] = 32'sh7FFF_FFFF - $signed($urandom_range(3)); // near max
                    default: vals[j] = $urandom;
                endcase
            // ascending order within a list
            for (int a = 1; a < n; a++)
                for (int b = a; b > 0 && vals[b] < vals[b-1]; b--)
                begin
                    tmp       = vals[b];
                    vals[b]   = vals[b-1];
                    vals[b-1] = tmp;
                end
            end_by_flag = 1'($urandom_range(1));
            for (int j = 0; j < n; j++)
            begin
                it.list_id      = l[LIST_ID_W-1:0];
                it.value        = vals[j];
                it.last_of_list = end_by_flag && (j == n - 1);
                it.list_empty   = 1'b0;
                list_feed[l].push_back(it);
            end
            if (!end_by_flag || n == 0)
            begin
                // empty report; its value and last flag are don't-cares
                it.list_id      = l[LIST_ID_W-1:0];
                it.value        = $urandom;
                it.last_of_list = 1'($urandom_range(1));
                it.list_empty   = 1'b1;
                list_feed[l].push_back(it);
            end
        end

        stream_closed = 1'b0;
        fed           = 0;
        while (!stream_closed)
        begin
            if ($urandom_range(99) < 10)
            begin
                // stray item: usually dropped, sometimes breaks the sequence
                it.list_id      = LIST_ID_W'($urandom_range(MAX_LISTS - 1));
                it.value        = $urandom;
                it.last_of_list = 1'($urandom_range(1));
                it.list_empty   = 1'($urandom_range(1));
            end
            else
            begin
                nc = 0;
                for (int l = 0; l < k; l++)
                    if (list_wait[l])
                    begin
                        cand[nc] = l;
                        nc++;
                    end
                if (nc == 0)
                    break;
                n = cand[$urandom_range(nc - 1)];
                if (list_feed[n].size() != 0)
                    it = list_feed[n].pop_front();
                else
                begin
                    it.list_id      = n[LIST_ID_W-1:0];
                    it.value        = $urandom;
                    it.last_of_list = 1'b0;
                    it.list_empty   = 1'b1;
                end
            end
            send_item(it, 1'b1, taken);
            if (taken)
            begin
                random_taken++;
                fed++;
            end
            // once, stop feeding mid-stream until the output catches up
            if (!held_once && fed == 3 && !stream_closed)
            begin
                drain_results();
                held_once = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit taken;
        lists_cfg = CFG_RESET;
        merge_restart();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, run under the first idling phase
        send_gap_pct   = 27;
        recv_stall_pct = 53;
        for (int r = 0; r < $size(dir_rows); r++)
        begin
            if (dir_rows[r].cfg_on)
                write_lists(dir_rows[r].cfg_val);
            send_item(dir_rows[r].item, dir_rows[r].chk == CHK_MODEL, taken);
            if (dir_rows[r].chk == CHK_ONE)
                merge_expect_q.push_back(dir_rows[r].want);
        end

        while (random_taken < RANDOM_ITEMS)
            run_stream();

        drain_results();
        repeat (END_CYC) @(posedge clk);

        $display("summary: %0d items sent, %0d taken, %0d random merges, %0d config writes",
                 items_sent, items_taken, streams, cfg_writes);
        $display("summary: %0d results checked, up to %0d per item, %0d mismatches",
                 results_seen, most_per_step, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
